// ===== rtl/core/mts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the min tracking stack
// Sizes, command and status codes and the entry decode used by the stack
// controller and its port checker.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int DEPTH       = 256;
   localparam int DATA_WIDTH  = 32;
   localparam int ENTRY_WIDTH = DATA_WIDTH + 2;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Result word: top, minimum, empty flag and count, padded to whole bytes.
   localparam int RSP_FIELDS_WIDTH = 2 * DATA_WIDTH + 1 + COUNT_WIDTH;
   localparam int RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int REQ_TDATA_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int STATUS_WIDTH     = 2;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSH_FULL  = 2'd2;

   localparam logic signed [DATA_WIDTH-1:0] DATA_MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DATA_NONE    = {DATA_WIDTH{1'b1}};

   typedef logic signed [DATA_WIDTH-1:0]  data_type;
   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;

   function automatic entry_type widen(input data_type v);
      widen = $signed({{(ENTRY_WIDTH-DATA_WIDTH){v[DATA_WIDTH-1]}}, v});
   endfunction

   // An entry below the running minimum is an encoded one, whose true value
   // is the minimum itself.
   function automatic data_type decode_top(input entry_type e, input data_type m);
      if (e < widen(m)) begin
         decode_top = m;
      end else begin
         decode_top = e[DATA_WIDTH-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/min_tracking_stack_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_unit: LIFO stack of signed words with running minimum
// Keeps one minimum register; entries pushed below the minimum are stored
// encoded so that popping them restores the previous minimum.
//
//   Channel  Direction  tdata                               tuser
//   req_     in         [31:0] value                        [0] cmd
//   rsp_     out        [31:0] top, [63:32] min, [64] empty, [1:0] status
//                       [73:65] count
//
// A push or a pop onto an empty stack is answered from the idle state. A
// pop that leaves entries behind goes through the read state: the new top
// has to be read back from the entry memory, whose read data is registered.
// Reset clears the pointer, the minimum and the handshake state; the memory
// needs no clearing pass. A stalled result holds the next word off.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit
   import mts_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0]  req_tdata,   // value
   input  wire logic                        req_tuser,   // cmd
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0]       rsp_tdata,   // top, min, empty, count
   output logic [STATUS_WIDTH-1:0]          rsp_tuser    // status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                          state_ff, state_in;
   logic [COUNT_WIDTH-1:0]        sp_ff, sp_in;
   data_type                      min_ff, min_in;
   entry_type                     top_ff, top_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic [STATUS_WIDTH-1:0]       rsp_status_ff, rsp_status_in;

   logic                          wr_en, rd_en;
   logic [ADDR_WIDTH-1:0]         wr_addr, rd_addr;
   entry_type                     wr_data, rd_data;

   logic                          accept, cmd, is_full, is_empty, below_min;
   data_type                      value;
   entry_type                     value_x, min_x, encoded, restored;
   logic [COUNT_WIDTH-1:0]        sp_dec;

   mts_entry_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign value      = $signed(req_tdata[DATA_WIDTH-1:0]);
   assign value_x    = widen(value);
   assign min_x      = widen(min_ff);
   assign encoded    = (value_x <<< 1) - min_x;
   assign restored   = (min_x <<< 1) - top_ff;
   assign is_full    = (sp_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty   = (sp_ff == '0);
   assign below_min  = (value < min_ff);
   assign sp_dec     = sp_ff - COUNT_WIDTH'(1);

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      min_in        = min_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = sp_ff[ADDR_WIDTH-1:0];
      wr_data       = value_x;
      rd_en         = 1'b0;
      rd_addr       = sp_dec[ADDR_WIDTH-1:0] - ADDR_WIDTH'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (cmd == CMD_PUSH) begin
                  if (is_full) begin
                     rsp_data_in   = RSP_TDATA_WIDTH'({sp_ff, 1'b0, min_ff,
                                                       decode_top(top_ff, min_ff)});
                     rsp_status_in = STATUS_PUSH_FULL;
                  end else begin
                     wr_en = 1'b1;
                     if (!is_empty && below_min) begin
                        wr_data = encoded;
                     end
                     if (is_empty || below_min) begin
                        min_in = value;
                     end
                     top_in        = wr_data;
                     sp_in         = sp_ff + COUNT_WIDTH'(1);
                     rsp_data_in   = RSP_TDATA_WIDTH'({sp_in, 1'b0, min_in, value});
                     rsp_status_in = STATUS_DONE;
                  end
               end else begin
                  if (is_empty) begin
                     rsp_data_in   = RSP_TDATA_WIDTH'({sp_ff, 1'b1, DATA_NONE, DATA_NONE});
                     rsp_status_in = STATUS_POP_EMPTY;
                  end else begin
                     if (top_ff <= min_x) begin
                        min_in = restored[DATA_WIDTH-1:0];
                     end
                     sp_in         = sp_dec;
                     rsp_status_in = STATUS_DONE;
                     if (sp_dec == '0) begin
                        rsp_data_in = RSP_TDATA_WIDTH'({sp_dec, 1'b1, DATA_NONE, DATA_NONE});
                     end else begin
                        // The new top lies one below the popped entry.
                        rd_en        = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            top_in        = rd_data;
            rsp_valid_in  = 1'b1;
            rsp_data_in   = RSP_TDATA_WIDTH'({sp_ff, 1'b0, min_ff,
                                              decode_top(rd_data, min_ff)});
            rsp_status_in = STATUS_DONE;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         min_ff       <= DATA_MAX_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mts_entry_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_entry_store: stack entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mts_entry_store
   import mts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_WIDTH-1:0]  wr_addr,
   input  wire entry_type              wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_WIDTH-1:0]  rd_addr,
   output entry_type                   rd_data
);

   entry_type entry_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mts_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_checker: port checks for the min tracking stack
// Watches the result channel, checks that a stalled word holds and that each word is self-consistent.
// ----------------------------------------------------------------------------
module mts_checker
   import mts_pkg::*;
(
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input wire logic [STATUS_WIDTH-1:0]     rsp_tuser
);

   localparam int EMPTY_BIT = 2 * DATA_WIDTH;

   logic                    rsp_empty;
   logic [COUNT_WIDTH-1:0]  rsp_count;
   data_type                rsp_top, rsp_min;

   assign rsp_top   = $signed(rsp_tdata[DATA_WIDTH-1:0]);
   assign rsp_min   = $signed(rsp_tdata[EMPTY_BIT-1:DATA_WIDTH]);
   assign rsp_empty = rsp_tdata[EMPTY_BIT];
   assign rsp_count = rsp_tdata[EMPTY_BIT+COUNT_WIDTH:EMPTY_BIT+1];

   // A word that is held back must not change.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_empty == (rsp_count == '0))
      else $error("empty flag disagrees with entry count");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_empty |-> rsp_top == DATA_NONE && rsp_min == DATA_NONE)
      else $error("empty stack must report top and minimum as -1");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_DONE
                  || (rsp_tuser == STATUS_POP_EMPTY && rsp_empty)
                  || (rsp_tuser == STATUS_PUSH_FULL && rsp_count == COUNT_WIDTH'(DEPTH)))
      else $error("status does not match the reported stack");

   a_top_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_empty |-> rsp_top >= rsp_min)
      else $error("top of stack below the reported minimum");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
